@@ src/vlr_pkg.sv @@
// vlr_pkg: shared types and constants for the voxel layer rotator
// layer width, coefficient format, register indexes and reset values
// no dependencies
package vlr_pkg;

    localparam int LAYER_BITS = 25;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int TDATA_W    = 32;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    typedef logic [LAYER_BITS-1:0]    layer_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // register index, taken from paddr[2]
    localparam logic REG_COS = 1'b0;
    localparam logic REG_SIN = 1'b1;

    localparam coef_t COS_RESET = 16'sd16384;
    localparam coef_t SIN_RESET = 16'sd0;

endpackage

@@ src/vlr_lane.sv @@
// vlr_lane: one source cell, maps a lit voxel to its rotated target bit
// registers a one-hot target mask; depends on vlr_pkg
module vlr_lane #(
    parameter int GRID_SIZE = 5,
    parameter int CELL_X    = 0,
    parameter int CELL_Y    = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  logic            lit,
    input  vlr_pkg::coef_t  cos_coef,
    input  vlr_pkg::coef_t  sin_coef,
    output vlr_pkg::layer_t target_reg
);

    localparam int PW  = vlr_pkg::COEF_W + 6;
    localparam int RW  = 10;
    localparam int IW  = 8;
    localparam int CTR = GRID_SIZE / 2;
    localparam logic signed [PW-1:0] DX   = PW'(CELL_X - CTR);
    localparam logic signed [PW-1:0] DY   = PW'(CELL_Y - CTR);
    localparam logic        [PW-1:0] HALF = PW'(1) << (vlr_pkg::FRAC_BITS - 1);
    localparam logic signed [RW-1:0] CTRS = RW'(CTR);
    localparam logic signed [RW-1:0] GS   = RW'(GRID_SIZE);

    // round half away from zero, q.14 to integer
    function automatic logic signed [RW-1:0] round_q14(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        r   = (mag + HALF) >> vlr_pkg::FRAC_BITS;
        round_q14 = v[PW-1] ? -$signed(r[RW-1:0]) : $signed(r[RW-1:0]);
    endfunction

    logic signed [PW-1:0] cw, sw, xq, yq;
    logic signed [RW-1:0] nx, ny;
    logic                 in_grid;
    logic [IW-1:0]        nidx;
    vlr_pkg::layer_t      target_next;

    always_comb begin
        cw = PW'(cos_coef);
        sw = PW'(sin_coef);
        // dx, dy are small constants: shift-add only
        xq = cw * DX - sw * DY;
        yq = sw * DX + cw * DY;
        nx = CTRS + round_q14(xq);
        ny = CTRS + round_q14(yq);
        in_grid = (nx >= 0) && (nx < GS) && (ny >= 0) && (ny < GS);
        nidx = IW'(nx[3:0]) + IW'(ny[3:0]) * IW'(GRID_SIZE);
        if (lit && in_grid && (nidx < IW'(vlr_pkg::LAYER_BITS))) begin
            target_next = vlr_pkg::layer_t'(1) << nidx;
        end else begin
            target_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            target_reg <= target_next;
        end
    end

endmodule

@@ src/vlr_merge.sv @@
// vlr_merge: ors the target masks of all lanes into the output layer
// registered; depends on vlr_pkg
module vlr_merge #(
    parameter int NLANE = 25
) (
    input  logic                              aclk,
    input  logic                              en,
    input  vlr_pkg::layer_t [NLANE-1:0]       lane_mask,
    output vlr_pkg::layer_t                   merged_reg
);

    vlr_pkg::layer_t merged_next;

    always_comb begin
        merged_next = '0;
        for (int i = 0; i < NLANE; i++) begin
            merged_next = merged_next | lane_mask[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            merged_reg <= merged_next;
        end
    end

endmodule

@@ src/voxel_layer_rotator_top.sv @@
// voxel_layer_rotator_top: rotates a square led cube layer about its center
// uses vlr_pkg, vlr_lane, vlr_merge
//
//   channel   dir  ports                          content
//   s_        in   s_tvalid/s_tready/s_tdata      source layer
//   m_        out  m_tvalid/m_tready/m_tdata      rotated layer
//   apb       in   psel/penable/pwrite/paddr/...  cos_coef @0, sin_coef @4
//
// one request per cycle while the m_ side keeps up; pipeline: lane stage then merge stage
// one lane per cell (at most LAYER_BITS); each target comes from cos/sin by shift-add
// a stalled m_ side holds both stages; a bubble in either stage is filled at once
// reset (aresetn low, synchronous) empties the pipe and restores cos 1.0, sin 0
module voxel_layer_rotator_top #(
    parameter int GRID_SIZE = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vlr_pkg::TDATA_W-1:0]   s_tdata,   // [24:0] layer_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vlr_pkg::TDATA_W-1:0]   m_tdata,   // [24:0] layer_out
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vlr_pkg::PADDR_W-1:0]   paddr,
    input  logic [vlr_pkg::PDATA_W-1:0]   pwdata,
    output logic [vlr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NCELL = GRID_SIZE * GRID_SIZE;
    localparam int NLANE = (NCELL < vlr_pkg::LAYER_BITS) ? NCELL : vlr_pkg::LAYER_BITS;

    vlr_pkg::coef_t cos_reg, sin_reg;
    logic           lane_valid_reg, out_valid_reg;
    logic           adv_lane, adv_out, wr_en;
    vlr_pkg::layer_t [NLANE-1:0] lane_mask;
    vlr_pkg::layer_t merged;

    // configuration
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg <= vlr_pkg::COS_RESET;
            sin_reg <= vlr_pkg::SIN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                vlr_pkg::REG_COS: cos_reg <= pwdata[vlr_pkg::COEF_W-1:0];
                vlr_pkg::REG_SIN: sin_reg <= pwdata[vlr_pkg::COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vlr_pkg::REG_COS: prdata = vlr_pkg::PDATA_W'(unsigned'(cos_reg));
            vlr_pkg::REG_SIN: prdata = vlr_pkg::PDATA_W'(unsigned'(sin_reg));
            default:          prdata = '0;
        endcase
    end

    // pipeline flow
    assign adv_out  = !out_valid_reg || m_tready;
    assign adv_lane = !lane_valid_reg || adv_out;
    assign s_tready = adv_lane;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (adv_lane) begin
                lane_valid_reg <= s_tvalid;
            end
            if (adv_out) begin
                out_valid_reg <= lane_valid_reg;
            end
        end
    end

    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        vlr_lane #(
            .GRID_SIZE (GRID_SIZE),
            .CELL_X    (i % GRID_SIZE),
            .CELL_Y    (i / GRID_SIZE)
        ) u_lane (
            .aclk       (aclk),
            .en         (adv_lane),
            .lit        (s_tdata[i]),
            .cos_coef   (cos_reg),
            .sin_coef   (sin_reg),
            .target_reg (lane_mask[i])
        );
    end

    vlr_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .aclk       (aclk),
        .en         (adv_out),
        .lane_mask  (lane_mask),
        .merged_reg (merged)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = vlr_pkg::TDATA_W'(merged);

    // checks
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although output side is ready");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (lane_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled with a free stage");

    a_accept_fills_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> lane_valid_reg)
        else $error("accepted request lost at lane stage");

    a_lane_moves_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid_reg && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("lane stage result not moved to output");

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for voxel_layer_rotator_top
// stream driver and monitor with an apb register writer, and a layer rotation predictor
// depends on vlr_pkg and voxel_layer_rotator_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID        = 5;
    localparam int CTR         = GRID / 2;
    localparam int NUM_PHASES  = 11;
    localparam int RAND_ITEMS  = 123;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [vlr_pkg::TDATA_W-1:0]  s_tdata  = '0;    // [24:0] layer_in
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [vlr_pkg::TDATA_W-1:0]  m_tdata;          // [24:0] layer_out
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [vlr_pkg::PADDR_W-1:0]  paddr    = '0;
    logic [vlr_pkg::PDATA_W-1:0]  pwdata   = '0;
    logic [vlr_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    vlr_pkg::layer_t source_layers[$];
    vlr_pkg::layer_t expected_layers[$];
    vlr_pkg::coef_t  cos_now = vlr_pkg::COS_RESET;
    vlr_pkg::coef_t  sin_now = vlr_pkg::SIN_RESET;

    logic   no_idle     = 1'b0;
    logic   hold_req    = 1'b0;
    logic   hold_taken  = 1'b0;
    int     hold_left   = 0;
    int     cycle_count = 0;
    int     accepted    = 0;
    int     checked     = 0;
    int     mismatches  = 0;

    voxel_layer_rotator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // q.14 to integer, halves away from zero
    function automatic int round_q14(int v);
        int mag;
        int r;
        mag = (v < 0) ? -v : v;
        r   = (mag + (1 << (vlr_pkg::FRAC_BITS - 1))) >>> vlr_pkg::FRAC_BITS;
        return (v < 0) ? -r : r;
    endfunction

    function automatic vlr_pkg::layer_t rotate_layer(vlr_pkg::layer_t src,
                                                     vlr_pkg::coef_t c, vlr_pkg::coef_t s);
        vlr_pkg::layer_t dst;
        int dx, dy, nx, ny;
        dst = '0;
        for (int y = 0; y < GRID; y++) begin
            for (int x = 0; x < GRID; x++) begin
                if (x + GRID * y < vlr_pkg::LAYER_BITS && src[x + GRID * y]) begin
                    dx = x - CTR;
                    dy = y - CTR;
                    nx = CTR + round_q14(int'(c) * dx - int'(s) * dy);
                    ny = CTR + round_q14(int'(s) * dx + int'(c) * dy);
                    // off-grid targets are dropped, never wrapped
                    if (nx >= 0 && nx < GRID && ny >= 0 && ny < GRID &&
                            nx + GRID * ny < vlr_pkg::LAYER_BITS)
                        dst[nx + GRID * ny] = 1'b1;
                end
            end
        end
        return dst;
    endfunction

    function automatic vlr_pkg::layer_t random_layer();
        vlr_pkg::layer_t v;
        case ($urandom_range(3))
            0: v = vlr_pkg::layer_t'($urandom);
            1: begin
                v = '0;
                repeat ($urandom_range(1, 3))
                    v[$urandom_range(vlr_pkg::LAYER_BITS - 1)] = 1'b1;
            end
            2: v = vlr_pkg::layer_t'($urandom | $urandom);
            default: v = vlr_pkg::layer_t'($urandom & $urandom & $urandom);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task automatic write_coef(logic reg_idx, vlr_pkg::coef_t value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= vlr_pkg::PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == vlr_pkg::REG_COS)
            cos_now = value;
        else
            sin_now = value;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (source_layers.size() != 0 || expected_layers.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    // driver: offers the next pending layer, records its rotation on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_layers.push_back(rotate_layer(s_tdata[vlr_pkg::LAYER_BITS-1:0],
                                                       cos_now, sin_now));
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (source_layers.size() != 0 && (no_idle || $urandom_range(99) >= 35)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= vlr_pkg::TDATA_W'(source_layers.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each result request against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_layers.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h",
                    m_tdata[vlr_pkg::LAYER_BITS-1:0]));
            end else begin
                vlr_pkg::layer_t want;
                want = expected_layers.pop_front();
                checked++;
                if (m_tdata[vlr_pkg::LAYER_BITS-1:0] !== want)
                    report_mismatch($sformatf("layer_out %h, expected %h",
                        m_tdata[vlr_pkg::LAYER_BITS-1:0], want));
            end
        end
        m_tready <= (hold_left == 0) && !(hold_req && !hold_taken) &&
                    (no_idle || $urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        vlr_pkg::layer_t directed[$];
        vlr_pkg::coef_t  c, s;
        directed = '{25'h0000000, 25'h1FFFFFF, 25'h0001000, 25'h0000001, 25'h0000010,
                     25'h0100000, 25'h1000000, 25'h1555555, 25'h0AAAAAA, 25'h0007C00,
                     25'h0108421, 25'h0739CE7};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            c = cos_now;
            s = sin_now;
            case (phase)
                1:  begin c = 16'sd11585;  s = 16'sd11585;  end    // 45 degrees
                2:  begin c = 16'sd0;      s = 16'sd16384;  end
                3:  begin c = -16'sd16384; s = 16'sd0;      end
                4:  begin c = vlr_pkg::coef_t'(-32768); s = 16'sd32767; end
                5:  begin c = 16'sd32767;  s = vlr_pkg::coef_t'(-32768); end
                6:  begin c = 16'sd14189;  s = 16'sd8192;   end    // 30 degrees
                7:  begin c = 16'sd16384;  s = 16'sd16384;  end    // scaled rotation
                8:  begin c = 16'sd0;      s = 16'sd0;      end    // everything to center
                9:  begin
                    c = vlr_pkg::coef_t'($urandom_range(32768) - 16384);
                    s = vlr_pkg::coef_t'($urandom_range(32768) - 16384);
                end
                10: begin c = vlr_pkg::coef_t'($urandom); s = vlr_pkg::coef_t'($urandom); end
                default: ;
            endcase
            if (phase != 0) begin
                write_coef(vlr_pkg::REG_COS, c);
                write_coef(vlr_pkg::REG_SIN, s);
            end
            @(negedge aclk);
            // phase 2 runs without idling and with one long receiver hold-off
            no_idle  <= (phase == 2);
            hold_req <= (phase == 2);
            if (phase < 2)
                foreach (directed[i]) source_layers.push_back(directed[i]);
            repeat (RAND_ITEMS) source_layers.push_back(random_layer());
            wait_drained();
            repeat (4) @(posedge aclk);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (expected_layers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_layers.size()));
        $display("ran %0d layers through %0d coefficient settings", accepted, NUM_PHASES);
        $display("checked %0d results, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/vlr_pkg.sv
src/vlr_lane.sv
src/vlr_merge.sv
src/voxel_layer_rotator_top.sv
bench/testbench.sv
